/* rtl/crfd_pkg.sv */
// Shared types, constants and helpers for the camera raw frame decoder.
// No dependencies; every other file of the block depends on this package.
package crfd_pkg;

  // Geometry of the pixel store and of one channel block
  localparam int CHANNEL_COUNT      = 16;
  localparam int PIXELS_PER_CHANNEL = 128;
  localparam int BLOCK_WORDS        = 43;

  // Field widths
  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 22;
  localparam int PIX_W   = 10;
  localparam int STAMP_W = 28;
  localparam int FH_W    = 12;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STRICT_CHECKS = 4'd1;
  localparam logic [FH_W-1:0]        FRAME_HEIGHT_RST  = 12'd1024;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error causes
  localparam logic [1:0] CAUSE_MAGIC      = 2'd0;
  localparam logic [1:0] CAUSE_CHAN_HEAD  = 2'd1;
  localparam logic [1:0] CAUSE_DATA_TAG   = 2'd2;
  localparam logic [1:0] CAUSE_BLOCK_TAIL = 2'd3;

  // Stream marker words
  localparam logic [31:0] REP_WORD    = 32'h0111_1111;
  localparam logic [31:0] SYNC_WORD   = 32'h5111_1111;
  localparam logic [31:0] FILL_WORD_A = 32'h89ab_cdef;
  localparam logic [31:0] FILL_WORD_B = 32'h0123_4567;
  localparam logic [9:0]  TAIL_MAGIC  = 10'h055;

  // Block header field codes
  localparam logic [1:0] TAG_HEAD   = 2'd2;
  localparam logic [1:0] TAG_DATA   = 2'd3;
  localparam logic [3:0] BIT_DEPTH  = 4'd10;
  localparam logic [3:0] HDR_NIBBLE = 4'h5;

  // Maximum results per stream word
  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  pixel_address;
    logic [PIX_W-1:0]   pixel_value;
    logic [STAMP_W-1:0] frame_id;
    logic [STAMP_W-1:0] capture_stamp;
    logic [1:0]         error_cause;
    logic               last;
  } crfd_result_t;

  // Physical channel to store channel
  function automatic logic [3:0] chan_map(input logic [3:0] c);
    logic [3:0] m;
    case (c)
      4'd0:    m = 4'd15;
      4'd1:    m = 4'd13;
      4'd2:    m = 4'd14;
      4'd3:    m = 4'd12;
      4'd4:    m = 4'd10;
      4'd5:    m = 4'd8;
      4'd6:    m = 4'd11;
      4'd7:    m = 4'd7;
      4'd8:    m = 4'd9;
      4'd9:    m = 4'd6;
      4'd10:   m = 4'd5;
      4'd11:   m = 4'd2;
      4'd12:   m = 4'd4;
      4'd13:   m = 4'd3;
      4'd14:   m = 4'd0;
      default: m = 4'd1;
    endcase
    return m;
  endfunction

endpackage

/* rtl/crfd_if.sv */
// Valid/ready channel interfaces for the camera raw frame decoder.
// Depends on crfd_pkg for widths and the result type.
interface crfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [crfd_pkg::WORD_W-1:0] data_word;
  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface crfd_out_if;
  logic                   valid;
  logic                   ready;
  crfd_pkg::crfd_result_t result;
  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

interface crfd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [crfd_pkg::CFG_INDEX_W-1:0] index;
  logic [crfd_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/crfd_parser.sv */
// Frame parser: holds the stream state and turns one word into up to three results.
// Depends on crfd_pkg; instantiated by camera_raw_frame_decoder_top.
module crfd_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [crfd_pkg::WORD_W-1:0]         word,
  input  logic                                fire,
  input  logic [crfd_pkg::FH_W-1:0]           frame_height,
  input  logic                                strict_checks,
  output logic [1:0]                          res_count,
  output crfd_pkg::crfd_result_t              res [crfd_pkg::MAX_RES]
);
  import crfd_pkg::*;

  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_BHEAD = 3'd1;
  localparam logic [2:0] PH_BDATA = 3'd2;
  localparam logic [2:0] PH_FOOT  = 3'd3;
  localparam logic [2:0] PH_POST0 = 3'd4;
  localparam logic [2:0] PH_POST1 = 3'd5;
  localparam logic [2:0] PH_FILL  = 3'd6;
  localparam logic [2:0] PH_HUNT  = 3'd7;

  logic [2:0]         phase_r, phase_nxt;
  logic [5:0]         wc_r, wc_nxt;
  logic [7:0]         bpix_r, bpix_nxt;
  logic [3:0]         bchan_r, bchan_nxt;
  logic [10:0]        brow_r, brow_nxt;
  logic [ADDR_W-1:0]  waddr_r, waddr_nxt;
  logic [STAMP_W-1:0] sfn_r, sfn_nxt;
  logic [STAMP_W-1:0] sts_r, sts_nxt;

  logic               do_hdr, do_fail;
  logic [1:0]         fail_cause;
  logic [2:0]         hidx;
  logic [3:0]         hnib, fnib;
  logic [31:0]        hdr_want, foot_want;
  logic [3:0]         bh_chan;
  logic [10:0]        bh_row;
  logic [7:0]         bh_pix;
  logic               bh_fix;
  logic [ADDR_W-1:0]  bh_base;
  logic [1:0]         tail_n;
  logic [FH_W-1:0]    row_plus1;

  function automatic crfd_result_t pix_res(input logic [ADDR_W-1:0] a,
                                           input logic [PIX_W-1:0] v);
    crfd_result_t r;
    r               = '0;
    r.kind          = KIND_PIXEL;
    r.pixel_address = a;
    r.pixel_value   = v;
    return r;
  endfunction

  // Decode one word against the current phase
  always_comb begin
    phase_nxt  = phase_r;
    wc_nxt     = wc_r;
    bpix_nxt   = bpix_r;
    bchan_nxt  = bchan_r;
    brow_nxt   = brow_r;
    waddr_nxt  = waddr_r;
    sfn_nxt    = sfn_r;
    sts_nxt    = sts_r;
    res_count  = 2'd0;
    for (int i = 0; i < MAX_RES; i++) res[i] = '0;
    do_hdr     = 1'b0;
    do_fail    = 1'b0;
    fail_cause = CAUSE_MAGIC;
    hidx       = wc_r[2:0];
    bh_chan    = chan_map(word[3:0]);
    bh_row     = word[14:4];
    bh_pix     = word[27:20];
    bh_fix     = (bh_row < 11'd2) && (bh_pix == 8'(PIXELS_PER_CHANNEL - 1));
    bh_base    = {bh_row, bh_chan, 7'd0};
    tail_n     = bpix_r[7:6];
    row_plus1  = {1'b0, brow_r} + 12'd1;
    fnib       = 4'd10 + {1'b0, wc_r[2:0]};
    if (wc_r[2:0] < 3'd6) begin
      foot_want = {4'h0, {7{fnib}}};
    end else if (wc_r[2:0] == 3'd6) begin
      foot_want = 32'd0;
    end else begin
      foot_want = REP_WORD;
    end

    case (phase_r)
      PH_HDR: begin
        do_hdr = 1'b1;
        hidx   = wc_r[2:0];
      end
      PH_BHEAD: begin
        if (strict_checks && (word[31:30] != TAG_HEAD || word[19:16] != BIT_DEPTH ||
            (!bh_fix && bh_pix != 8'(PIXELS_PER_CHANNEL)))) begin
          do_fail    = 1'b1;
          fail_cause = CAUSE_CHAN_HEAD;
        end else begin
          bchan_nxt = bh_chan;
          brow_nxt  = bh_row;
          bpix_nxt  = bh_pix;
          phase_nxt = PH_BDATA;
          wc_nxt    = 6'd1;
          // write the missing first pixel as zero
          if (bh_fix) begin
            res[0]    = pix_res(bh_base, '0);
            res_count = 2'd1;
            waddr_nxt = bh_base + 22'd1;
          end else begin
            waddr_nxt = bh_base;
          end
        end
      end
      PH_BDATA: begin
        if (strict_checks && word[31:30] != TAG_DATA) begin
          do_fail    = 1'b1;
          fail_cause = CAUSE_DATA_TAG;
        end else if (wc_r < 6'(BLOCK_WORDS)) begin
          res[0]    = pix_res(waddr_r, word[29:20]);
          res[1]    = pix_res(waddr_r + 22'd1, word[19:10]);
          res[2]    = pix_res(waddr_r + 22'd2, word[9:0]);
          res_count = 2'd3;
          waddr_nxt = waddr_r + 22'd3;
          wc_nxt    = wc_r + 6'd1;
        end else if (strict_checks && word[9:0] != TAIL_MAGIC) begin
          do_fail    = 1'b1;
          fail_cause = CAUSE_BLOCK_TAIL;
        end else begin
          // tail word: extra pixels sit above the magic field
          case (tail_n)
            2'd1: begin
              res[0] = pix_res(waddr_r, word[19:10]);
            end
            2'd2: begin
              res[0] = pix_res(waddr_r, word[29:20]);
              res[1] = pix_res(waddr_r + 22'd1, word[19:10]);
            end
            2'd3: begin
              res[0] = pix_res(waddr_r, {8'd0, word[31:30]});
              res[1] = pix_res(waddr_r + 22'd1, word[29:20]);
              res[2] = pix_res(waddr_r + 22'd2, word[19:10]);
            end
            default: begin
            end
          endcase
          res_count = tail_n;
          waddr_nxt = waddr_r + {20'd0, tail_n};
          wc_nxt    = 6'd0;
          if (row_plus1 < frame_height || bchan_r != 4'd1) begin
            phase_nxt = PH_BHEAD;
          end else begin
            phase_nxt = PH_FOOT;
          end
        end
      end
      PH_FOOT: begin
        if (strict_checks && word != foot_want) begin
          do_fail = 1'b1;
        end else if (wc_r[2:0] == 3'd7) begin
          phase_nxt            = PH_POST0;
          wc_nxt               = 6'd0;
          res[0].kind          = KIND_DONE;
          res[0].frame_id      = sfn_r;
          res[0].capture_stamp = sts_r;
          res_count            = 2'd1;
        end else begin
          wc_nxt = wc_r + 6'd1;
        end
      end
      PH_POST0: begin
        if (word == 32'd0) begin
          phase_nxt = PH_POST1;
        end else begin
          do_hdr = 1'b1;
          hidx   = 3'd0;
        end
      end
      PH_POST1: begin
        if (word == REP_WORD) begin
          phase_nxt = PH_FILL;
        end else if (strict_checks) begin
          do_fail = 1'b1;
        end else begin
          do_hdr = 1'b1;
          hidx   = 3'd1;
        end
      end
      PH_FILL: begin
        if (word != FILL_WORD_A && word != FILL_WORD_B) begin
          do_hdr = 1'b1;
          hidx   = 3'd0;
        end
      end
      default: begin
        // hunt: drop words until the first header word shows up
        if (word == SYNC_WORD) begin
          phase_nxt = PH_HDR;
          wc_nxt    = 6'd1;
        end
      end
    endcase

    // Frame header word
    hnib     = {1'b0, hidx} + 4'd1;
    hdr_want = {HDR_NIBBLE, {7{hnib}}};
    if (do_hdr) begin
      if (strict_checks && ((hidx < 3'd6) ? (word != hdr_want)
                                          : (word[31:28] != HDR_NIBBLE))) begin
        do_fail = 1'b1;
      end else begin
        if (hidx == 3'd6) sfn_nxt = word[27:0];
        if (hidx == 3'd7) sts_nxt = word[27:0];
        if (hidx == 3'd7) begin
          phase_nxt = PH_BHEAD;
          wc_nxt    = 6'd0;
        end else begin
          phase_nxt = PH_HDR;
          wc_nxt    = {3'd0, hidx} + 6'd1;
        end
      end
    end

    // Error: one result, then hunt
    if (do_fail) begin
      phase_nxt          = PH_HUNT;
      wc_nxt             = 6'd0;
      res[0]             = '0;
      res[0].kind        = KIND_ERROR;
      res[0].error_cause = fail_cause;
      res_count          = 2'd1;
    end

    // Mark the last result of this word
    for (int i = 0; i < MAX_RES; i++) begin
      res[i].last = (res_count == 2'(i + 1));
    end
  end

  // Advance the stream state on each consumed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      wc_r    <= '0;
      bpix_r  <= '0;
      bchan_r <= '0;
      brow_r  <= '0;
      waddr_r <= '0;
      sfn_r   <= '0;
      sts_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      wc_r    <= wc_nxt;
      bpix_r  <= bpix_nxt;
      bchan_r <= bchan_nxt;
      brow_r  <= brow_nxt;
      waddr_r <= waddr_nxt;
      sfn_r   <= sfn_nxt;
      sts_r   <= sts_nxt;
    end
  end

  // An error always ends in the hunt phase
  a_err_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_count != 2'd0 && res[0].kind == KIND_ERROR |=> phase_r == PH_HUNT)
    else $error("error result did not enter hunt");

  // Data word count stays within the block
  a_wc_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BDATA |-> wc_r >= 6'd1 && wc_r <= 6'(BLOCK_WORDS))
    else $error("block word count out of range");

  // Three results only come from a data word
  a_three_data: assert property (@(posedge clk) disable iff (!rst_n)
    res_count == 2'd3 |-> phase_r == PH_BDATA && res[0].kind == KIND_PIXEL)
    else $error("burst of three outside block data");

endmodule

/* rtl/camera_raw_frame_decoder_top.sv */
// Top level of the camera raw frame decoder: input register, parser, result buffer.
// Depends on crfd_pkg, crfd_if (channel interfaces) and crfd_parser.
//
//  channel  dir  handshake    payload
//  in_ch    in   valid/ready  data_word[31:0]
//  out_ch   out  valid/ready  result: kind, pixel_address, pixel_value,
//                             frame_id, capture_stamp, error_cause, last
//  cfg_ch   in   valid/ready  index[3:0], data[11:0] (ready always high)
//
// A data word makes three pixel results, which leave one at a time on the
// one-result-wide output; header, footer and fill words make at most one result.
// The output port is the limit: a word is parsed once its results fit the
// three-entry result buffer, which reloads in the cycle its last entry leaves.
// An accepted word waits in the input register, its results in the result buffer.
// rst_n is synchronous; it clears parse state and valids and resets the settings.
// Output stalls back up through the buffer to in_ch.ready; nothing is dropped.
module camera_raw_frame_decoder_top (
  input  logic      clk,
  input  logic      rst_n,
  crfd_in_if.sink   in_ch,
  crfd_out_if.source out_ch,
  crfd_cfg_if.sink  cfg_ch
);
  import crfd_pkg::*;

  logic [FH_W-1:0]   frame_height_r;
  logic              strict_r;
  logic [WORD_W-1:0] word_r;
  logic              word_v_r;
  crfd_result_t      ent_r [MAX_RES];
  logic [1:0]        cnt_r;
  crfd_result_t      res [MAX_RES];
  logic [1:0]        res_count;
  logic              take, buf_free, fire, load;

  // Configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_height_r <= FRAME_HEIGHT_RST;
      strict_r       <= 1'b0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_FRAME_HEIGHT)  frame_height_r <= cfg_ch.data;
      if (cfg_ch.index == REG_STRICT_CHECKS) strict_r       <= cfg_ch.data[0];
    end
  end

  // Consume the held word once its results fit
  assign take     = out_ch.valid && out_ch.ready;
  assign buf_free = (cnt_r == 2'd0) || (take && cnt_r == 2'd1);
  assign fire     = word_v_r && (res_count == 2'd0 || buf_free);
  assign load     = fire && res_count != 2'd0;
  assign in_ch.ready = !word_v_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      word_v_r <= 1'b1;
    end else if (fire) begin
      word_v_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) word_r <= in_ch.data_word;
  end

  crfd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .word          (word_r),
    .fire          (fire),
    .frame_height  (frame_height_r),
    .strict_checks (strict_r),
    .res_count     (res_count),
    .res           (res)
  );

  // Result buffer: load a burst, shift one out per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= res_count;
    end else if (take) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) ent_r[i] <= res[i];
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) ent_r[i] <= ent_r[i+1];
    end
  end

  assign out_ch.valid  = (cnt_r != 2'd0);
  assign out_ch.result = ent_r[0];

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd3)
    else $error("result buffer count overflow");

  // The head carries last exactly when it is the final entry
  a_last_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (ent_r[0].last == (cnt_r == 2'd1)))
    else $error("last flag out of step with buffer count");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 2'd0 || (take && cnt_r == 2'd1)))
    else $error("burst loaded over pending results");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    load && res[0].kind == KIND_ERROR |=> cnt_r == 2'd1)
    else $error("error burst holds more than one result");

endmodule

/* bench/crfd_score_pkg.sv */
// Scoreboard for the camera raw frame decoder bench: a bit-exact stream predictor
// plus the queue of expected results and the result checks. Depends on crfd_pkg.
package crfd_score_pkg;
  import crfd_pkg::*;

  // Parser position within the camera stream
  typedef enum logic [2:0] {
    SP_HEADER,
    SP_BLOCK_HEAD,
    SP_BLOCK_BODY,
    SP_FOOTER,
    SP_POST_ZERO,
    SP_POST_REP,
    SP_FILL,
    SP_HUNT
  } stream_phase_t;

  // Store channel whose block can close a frame, and the raw code that maps to it
  localparam logic [3:0] CLOSING_CHANNEL = 4'd1;
  localparam logic [3:0] CLOSING_CODE    = 4'd15;

  class frame_decode_scoreboard_t;
    logic [FH_W-1:0]    frame_height;
    bit                 strict;
    stream_phase_t      phase;
    int unsigned        word_idx;
    logic [7:0]         blk_pixels;
    logic [3:0]         blk_chan;
    logic [10:0]        blk_row;
    logic [ADDR_W-1:0]  wr_addr;
    logic [STAMP_W-1:0] held_frame;
    logic [STAMP_W-1:0] held_stamp;
    logic [3:0]         store_chan [16];
    crfd_result_t       word_results[$];
    crfd_result_t       expected_q[$];
    int unsigned        mismatches;
    int unsigned        strays;
    int unsigned        reports;
    int unsigned        pixel_count;
    int unsigned        done_count;
    int unsigned        error_count;

    function new();
      store_chan = '{4'd15, 4'd13, 4'd14, 4'd12, 4'd10, 4'd8, 4'd11, 4'd7,
                     4'd9, 4'd6, 4'd5, 4'd2, 4'd4, 4'd3, 4'd0, 4'd1};
      frame_height = FRAME_HEIGHT_RST;
      strict       = 1'b0;
      phase        = SP_HEADER;
      word_idx     = 0;
      blk_pixels   = '0;
      blk_chan     = '0;
      blk_row      = '0;
      wr_addr      = '0;
      held_frame   = '0;
      held_stamp   = '0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FRAME_HEIGHT) frame_height = data[FH_W-1:0];
      else if (idx == REG_STRICT_CHECKS) strict = data[0];
    endfunction

    function void add_result(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                             logic [PIX_W-1:0] val, logic [STAMP_W-1:0] fnum,
                             logic [STAMP_W-1:0] tstamp, logic [1:0] cause);
      crfd_result_t r;
      r.kind          = kind;
      r.pixel_address = addr;
      r.pixel_value   = val;
      r.frame_id      = fnum;
      r.capture_stamp = tstamp;
      r.error_cause   = cause;
      r.last          = 1'b0;
      word_results.push_back(r);
    endfunction

    // Write one pixel and advance the store address (wraps at 22 bits)
    function void add_pixel(logic [PIX_W-1:0] val);
      add_result(KIND_PIXEL, wr_addr, val, '0, '0, '0);
      wr_addr = wr_addr + 1'b1;
    endfunction

    // Drop the word, report it and hunt for the next sync word
    function void flag_error(logic [1:0] cause);
      phase    = SP_HUNT;
      word_idx = 0;
      word_results.delete();
      add_result(KIND_ERROR, '0, '0, '0, '0, cause);
    endfunction

    function void take_header(logic [WORD_W-1:0] w);
      bit bad;
      if (strict) begin
        bad = (word_idx < 6) ? (w != SYNC_WORD + word_idx * REP_WORD)
                             : (w[31:28] != HDR_NIBBLE);
        if (bad) begin
          flag_error(CAUSE_MAGIC);
          return;
        end
      end
      if (word_idx == 6) held_frame = w[STAMP_W-1:0];
      if (word_idx == 7) held_stamp = w[STAMP_W-1:0];
      word_idx++;
      if (word_idx >= 8) begin
        phase    = SP_BLOCK_HEAD;
        word_idx = 0;
      end
    endfunction

    function void take_block_head(logic [WORD_W-1:0] w);
      logic [10:0] row;
      logic [7:0]  pix;
      bit          short_row;
      row = w[14:4];
      pix = w[27:20];
      // rows 0 and 1 may arrive one pixel short; the gap is filled with zero
      short_row = (row < 2) && (pix == PIXELS_PER_CHANNEL - 1);
      if (strict && (w[31:30] != TAG_HEAD || w[19:16] != BIT_DEPTH ||
                     (!short_row && pix != PIXELS_PER_CHANNEL))) begin
        flag_error(CAUSE_CHAN_HEAD);
        return;
      end
      blk_chan   = store_chan[w[3:0]];
      blk_row    = row;
      blk_pixels = pix;
      wr_addr    = {row, blk_chan, 7'd0};
      phase      = SP_BLOCK_BODY;
      word_idx   = 1;
      if (short_row) add_pixel('0);
    endfunction

    function void take_block_body(logic [WORD_W-1:0] w);
      int unsigned tail_count;
      logic [31:0] shifted;
      if (strict && w[31:30] != TAG_DATA) begin
        flag_error(CAUSE_DATA_TAG);
        return;
      end
      if (word_idx < BLOCK_WORDS) begin
        add_pixel(w[29:20]);
        add_pixel(w[19:10]);
        add_pixel(w[9:0]);
        word_idx++;
        return;
      end
      if (strict && w[9:0] != TAIL_MAGIC) begin
        flag_error(CAUSE_BLOCK_TAIL);
        return;
      end
      // Tail word: highest-placed pixel first
      tail_count = blk_pixels >> 6;
      for (int j = 0; j < tail_count; j++) begin
        shifted = w >> (10 * (tail_count - j));
        add_pixel(shifted[PIX_W-1:0]);
      end
      word_idx = 0;
      if (int'(blk_row) < int'(frame_height) - 1 || blk_chan != CLOSING_CHANNEL)
        phase = SP_BLOCK_HEAD;
      else
        phase = SP_FOOTER;
    endfunction

    function void take_footer(logic [WORD_W-1:0] w);
      logic [31:0] want;
      if (strict) begin
        want = (word_idx < 6) ? (10 + word_idx) * REP_WORD : (word_idx == 6 ? '0 : REP_WORD);
        if (w != want) begin
          flag_error(CAUSE_MAGIC);
          return;
        end
      end
      word_idx++;
      if (word_idx >= 8) begin
        phase    = SP_POST_ZERO;
        word_idx = 0;
        add_result(KIND_DONE, '0, '0, held_frame, held_stamp, '0);
      end
    endfunction

    // Predict the results of one accepted stream word and queue them
    function void note_word(logic [WORD_W-1:0] w);
      word_results.delete();
      case (phase)
        SP_HEADER:     take_header(w);
        SP_BLOCK_HEAD: take_block_head(w);
        SP_BLOCK_BODY: take_block_body(w);
        SP_FOOTER:     take_footer(w);
        SP_POST_ZERO: begin
          if (w == '0) begin
            phase = SP_POST_REP;
          end else begin
            phase    = SP_HEADER;
            word_idx = 0;
            take_header(w);
          end
        end
        SP_POST_REP: begin
          if (w == REP_WORD) begin
            phase = SP_FILL;
          end else if (strict) begin
            flag_error(CAUSE_MAGIC);
          end else begin
            // the lone zero stood for header word 1
            phase    = SP_HEADER;
            word_idx = 1;
            take_header(w);
          end
        end
        SP_FILL: begin
          if (w != FILL_WORD_A && w != FILL_WORD_B) begin
            phase    = SP_HEADER;
            word_idx = 0;
            take_header(w);
          end
        end
        default: begin
          if (w == SYNC_WORD) begin
            phase    = SP_HEADER;
            word_idx = 1;
          end
        end
      endcase
      if (word_results.size() > 0) word_results[word_results.size() - 1].last = 1'b1;
      foreach (word_results[i]) expected_q.push_back(word_results[i]);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(crfd_result_t got);
      crfd_result_t want;
      if (expected_q.size() == 0) begin
        strays++;
        if (reports < 10) begin
          reports++;
          $display("unexpected result: kind %0d address %h value %h cause %0d",
                   got.kind, got.pixel_address, got.pixel_value, got.error_cause);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.pixel_address !== want.pixel_address ||
          got.pixel_value !== want.pixel_value || got.frame_id !== want.frame_id ||
          got.capture_stamp !== want.capture_stamp ||
          got.error_cause !== want.error_cause || got.last !== want.last) begin
        mismatches++;
        if (reports < 10) begin
          reports++;
          $display("result mismatch (expected/actual): kind %0d/%0d address %h/%h value %h/%h",
                   want.kind, got.kind, want.pixel_address, got.pixel_address,
                   want.pixel_value, got.pixel_value);
          $display("  frame %h/%h stamp %h/%h cause %0d/%0d last %0b/%0b",
                   want.frame_id, got.frame_id, want.capture_stamp, got.capture_stamp,
                   want.error_cause, got.error_cause, want.last, got.last);
        end
      end
      case (want.kind)
        KIND_PIXEL: pixel_count++;
        KIND_DONE:  done_count++;
        default:    error_count++;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function bit clean();
      return mismatches == 0 && strays == 0 && expected_q.size() == 0;
    endfunction
  endclass

endpackage

/* bench/camera_raw_frame_decoder_top_tb.sv */
// Bench top for camera_raw_frame_decoder_top: drives framed camera streams with
// random gaps and stalls. Depends on crfd_pkg, crfd_if, crfd_score_pkg and the RTL.
module camera_raw_frame_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crfd_pkg::*;
  import crfd_score_pkg::*;

  logic clk;
  logic rst_n;

  crfd_in_if  in_ch();
  crfd_out_if out_ch();
  crfd_cfg_if cfg_ch();

  camera_raw_frame_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_decode_scoreboard_t sb;
  bit              steady;     // no gaps and no stalls on either side
  bit              drop_sync;  // next frame starts at header word 2
  logic [FH_W-1:0] cur_fh;
  bit              cur_strict;
  int unsigned     words_sent;
  int unsigned     settings_used;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Stall the result side at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 27);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.result);
  end

  // Send one stream word, with random idle cycles ahead of it
  task automatic send_word(logic [WORD_W-1:0] w);
    while (!steady && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_word <= w;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    sb.note_word(w);
  endtask

  task automatic send_seq(input logic [WORD_W-1:0] seq[$]);
    foreach (seq[i]) send_word(seq[i]);
  endtask

  // Drop valid, let all expected results drain, then allow the pipe to empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write both registers back to back while the decoder is idle
  task automatic write_settings(logic [FH_W-1:0] fh, bit strict_on);
    for (int i = 0; i < 2; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= (i == 0) ? REG_FRAME_HEIGHT : REG_STRICT_CHECKS;
      // upper bits of the strict request are don't-care
      cfg_ch.data  <= (i == 0) ? fh : {11'($urandom), strict_on};
      do @(posedge clk); while (!cfg_ch.ready);
      sb.write_reg(cfg_ch.index, cfg_ch.data);
    end
    cfg_ch.valid <= 1'b0;
    cur_fh     = fh;
    cur_strict = strict_on;
    settings_used++;
  endtask

  function automatic logic [31:0] block_head_word(logic [1:0] tag, logic [7:0] pix,
                                                  logic [3:0] depth, logic [10:0] row,
                                                  logic [3:0] code);
    return {tag, 2'($urandom), pix, depth, 1'($urandom), row, code};
  endfunction

  // Build one well-formed frame for the current settings, with random content
  task automatic build_frame(ref logic [WORD_W-1:0] seq[$]);
    int unsigned nblk;
    int unsigned lo;
    logic [10:0] row;
    logic [7:0]  pix;
    logic [3:0]  code;
    logic [1:0]  tag;
    logic [3:0]  depth;
    seq.delete();
    for (int k = drop_sync ? 2 : 1; k <= 6; k++) seq.push_back(SYNC_WORD + (k - 1) * REP_WORD);
    repeat (2) begin
      seq.push_back((!cur_strict && $urandom_range(7) == 0) ? $urandom
                                                            : {HDR_NIBBLE, 28'($urandom)});
    end
    drop_sync = 1'b0;
    nblk = ($urandom_range(3) == 0) ? 2 : 1;
    lo   = (cur_fh >= 1 && cur_fh <= 2048) ? cur_fh - 1 : 0;
    for (int b = 0; b < nblk; b++) begin
      // only the last block can close the frame
      if (b == nblk - 1) begin
        code = CLOSING_CODE;
        row  = $urandom_range(1) ? 11'(lo) : 11'($urandom_range(2047, lo));
      end else begin
        code = 4'($urandom_range(CLOSING_CODE - 1));
        row  = $urandom_range(2) ? 11'($urandom_range(2047)) : 11'($urandom_range(1));
      end
      if (row < 2 && $urandom_range(1)) pix = 8'(PIXELS_PER_CHANNEL - 1);
      else if (cur_strict || $urandom_range(1)) pix = 8'(PIXELS_PER_CHANNEL);
      else pix = 8'($urandom_range(255));
      tag   = TAG_HEAD;
      depth = BIT_DEPTH;
      if (!cur_strict && $urandom_range(3) == 0) begin
        tag   = 2'($urandom_range(3));
        depth = 4'($urandom_range(15));
      end
      seq.push_back(block_head_word(tag, pix, depth, row, code));
      repeat (BLOCK_WORDS - 1) begin
        seq.push_back((cur_strict || $urandom_range(1)) ? {TAG_DATA, 30'($urandom)} : $urandom);
      end
      seq.push_back(cur_strict ? {TAG_DATA, 20'($urandom), TAIL_MAGIC} : $urandom);
    end
    // Footer: 0x0AAAAAAA .. 0x0FFFFFFF, zero, repeat word
    for (int i = 0; i < 6; i++) seq.push_back((10 + i) * REP_WORD);
    seq.push_back('0);
    seq.push_back(REP_WORD);
    case ($urandom_range(3))
      1: begin
        seq.push_back('0);
        seq.push_back(REP_WORD);
        repeat ($urandom_range(3)) seq.push_back($urandom_range(1) ? FILL_WORD_A : FILL_WORD_B);
      end
      2: begin
        seq.push_back('0);
        drop_sync = 1'b1;
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [WORD_W-1:0] seq[$];
    logic [FH_W-1:0]   fh_plan [4];
    bit                strict_plan [4];
    int unsigned       phase_words;
    int unsigned       pos;
    int unsigned       pick;

    sb = new();
    steady     = 1'b0;
    drop_sync  = 1'b0;
    words_sent = 0;
    settings_used = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_word <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: strict checks, one-row frames
    write_settings(12'd1, 1'b1);
    for (int k = 1; k <= 6; k++) seq.push_back(SYNC_WORD + (k - 1) * REP_WORD);
    seq.push_back(32'h5FFF_FFFF);
    seq.push_back(32'h5000_0000);
    // short row 0: zero fill, then all-ones and all-zero pixels
    seq.push_back(block_head_word(TAG_HEAD, 8'(PIXELS_PER_CHANNEL - 1), BIT_DEPTH,
                                  11'd0, CLOSING_CODE));
    seq.push_back(32'hFFFF_FFFF);
    seq.push_back(32'hC000_0000);
    // bad data tag, then hunt past near-misses of the sync word
    seq.push_back(32'h3FFF_FFFF);
    seq.push_back(32'hFFFF_FFFF);
    seq.push_back(32'h5000_0000);
    // resync, then a broken header word 2
    seq.push_back(SYNC_WORD);
    seq.push_back(SYNC_WORD + REP_WORD + 1);
    seq.push_back('0);
    for (int k = 1; k <= 6; k++) seq.push_back(SYNC_WORD + (k - 1) * REP_WORD);
    seq.push_back(32'h5000_0001);
    seq.push_back(32'h5FFF_FFFE);
    // wrong bit depth on row 2047
    seq.push_back(block_head_word(TAG_HEAD, 8'(PIXELS_PER_CHANNEL), 4'd9, 11'h7FF, 4'd0));
    send_seq(seq);
    settle();

    // Random frames over a range of settings, extremes included
    fh_plan     = '{12'd1, 12'd2048, 12'd0, 12'd4095};
    strict_plan = '{1'b1, 1'b0, 1'b1, 1'b1};
    for (int s = 0; s < 4; s++) begin
      write_settings(fh_plan[s], strict_plan[s]);
      steady = (s == 1);
      phase_words = 0;
      while (phase_words < 36) begin
        pick = $urandom_range(9);
        if (pick <= 8) begin
          build_frame(seq);
          // corrupt one word and sometimes cut the frame short
          if (pick >= 7) begin
            pos = $urandom_range(seq.size() - 1);
            if ($urandom_range(1)) seq[pos] = seq[pos] ^ (32'd1 << $urandom_range(31));
            else seq[pos] = $urandom;
            if ($urandom_range(1)) begin
              while (seq.size() > pos + 1) void'(seq.pop_back());
              drop_sync = 1'b0;
            end
          end
        end else begin
          seq.delete();
          repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(5))
              0:       seq.push_back(SYNC_WORD);
              1:       seq.push_back('0);
              2:       seq.push_back(REP_WORD);
              3:       seq.push_back(FILL_WORD_A);
              4:       seq.push_back(FILL_WORD_B);
              default: seq.push_back($urandom);
            endcase
          end
        end
        send_seq(seq);
        phase_words += seq.size();
      end
      settle();
    end
    steady = 1'b0;

    if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
    $display("Ran %0d stream words under %0d register settings.", words_sent, settings_used);
    $display("Checked %0d pixel writes, %0d completed frames, %0d flagged errors.",
             sb.pixel_count, sb.done_count, sb.error_count);
    if (sb.clean()) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d unexpected results", sb.mismatches, sb.strays);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
